>>> rtl/orsm_pkg.sv
// Package for the overlapping region slot map: transaction types, codes and defaults.
package orsm_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    // match classes
    localparam logic [2:0] CLS_PARTIAL   = 3'd0;
    localparam logic [2:0] CLS_EXACT     = 3'd1;
    localparam logic [2:0] CLS_CONTAINED = 3'd2;
    localparam logic [2:0] CLS_CONTAINS  = 3'd3;
    localparam logic [2:0] CLS_NONE      = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_FULL         = 2'd1;
    localparam logic [1:0] ST_LOOKUP_CONTS = 2'd2;
    localparam logic [1:0] ST_INCONSISTENT = 2'd3;

    // kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] region_offset;
        logic [3:0]  region_size;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  match_class;
        logic        found;
        logic [63:0] enclosing_offset;
        logic [3:0]  enclosing_size;
    } out_t;

    // per-slot compare outcome
    typedef struct packed {
        logic overlap;
        logic equal;
        logic slot_encloses;
        logic region_encloses;
    } cmp_t;

endpackage

>>> rtl/orsm_cmp.sv
// Shared region compare unit: one slot against the captured access region.
module orsm_cmp (
    input  logic [63:0]       region_offset,
    input  logic [64:0]       region_end,
    input  logic [3:0]        region_size,
    input  logic [63:0]       slot_offset,
    input  logic [3:0]        slot_size,
    output orsm_pkg::cmp_t    res
);
    import orsm_pkg::*;

    logic [64:0] slot_end;
    logic [64:0] r_off_x;
    logic [64:0] s_off_x;

    // ends are 65-bit, no wrap
    assign slot_end = {1'b0, slot_offset} + {61'd0, slot_size};
    assign r_off_x  = {1'b0, region_offset};
    assign s_off_x  = {1'b0, slot_offset};

    always_comb
    begin
        res.overlap         = (r_off_x < slot_end) && (s_off_x < region_end);
        res.equal           = (slot_offset == region_offset) && (slot_size == region_size);
        res.slot_encloses   = (slot_offset <= region_offset) && (region_end <= slot_end);
        res.region_encloses = (region_offset <= slot_offset) && (slot_end <= region_end);
    end

endmodule

>>> rtl/overlapping_region_slot_map_unit.sv
// Top level of the overlapping region slot map: sequencer, slot table, result register.
//
//  Channel   Signals            Handshake
//  --------  -----------------  ------------------------------------------------
//  command   start, busy, cmd   transaction taken at a clock edge with start & !busy
//  result    done, result       result valid for the single cycle done is high
//
// Sequence: a transaction runs a classify pass over every slot, a decide step
// and, for a consistent nonzero-size update classed partial overlap, contains
// slots or no match (a full table included), an update pass over every slot;
// done rises on the following cycle. The single compare unit visits one slot
// per cycle.
// busy drops in the cycle done is high, so the next command may be taken then.
// Reset empties the table at once (valid bits only); no clearing pass.
// The receiver cannot stall: done is a one-cycle strobe.
module overlapping_region_slot_map_unit #(
    parameter int SLOT_COUNT = orsm_pkg::SLOT_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  orsm_pkg::in_t cmd,
    output logic          done,
    output orsm_pkg::out_t result
);
    import orsm_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_DECIDE,
        S_UPDATE
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  idx_reg;

    // captured transaction
    logic              kind_reg;
    logic [63:0]       r_off_reg;
    logic [3:0]        r_size_reg;
    logic [64:0]       r_end_reg;

    // slot table: valid bits reset, payload written only on allocation
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [63:0]           slot_start_reg  [SLOT_COUNT];
    logic [3:0]            slot_length_reg [SLOT_COUNT];

    // classify accumulators
    logic              eq_seen_reg, eq_multi_reg;
    logic              encl_seen_reg, encl_multi_reg;
    logic              any_contained_reg, any_partial_reg;
    logic [63:0]       encl_off_reg;
    logic [3:0]        encl_len_reg;
    logic [SLOT_COUNT-1:0] ovl_mask_reg;

    // update pass control
    logic              inval_reg, alloc_reg, placed_reg;

    logic              done_reg;
    out_t              result_reg;

    cmp_t              cmp;
    logic              last;
    logic              size_nz;
    logic              hit;
    logic [2:0]        cls_next;
    logic              bad_next;
    logic              vacant;
    logic              do_alloc;

    orsm_cmp u_cmp (
        .region_offset (r_off_reg),
        .region_end    (r_end_reg),
        .region_size   (r_size_reg),
        .slot_offset   (slot_start_reg[idx_reg]),
        .slot_size     (slot_length_reg[idx_reg]),
        .res           (cmp)
    );

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;
    assign last    = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign size_nz = (r_size_reg != 4'd0);
    assign hit     = slot_valid_reg[idx_reg] && cmp.overlap && size_nz;

    // slot is free after this pass's invalidation
    assign vacant   = !slot_valid_reg[idx_reg] || (inval_reg && ovl_mask_reg[idx_reg]);
    assign do_alloc = (state_reg == S_UPDATE) && alloc_reg && !placed_reg && vacant;

    // classification by priority, plus consistency check
    always_comb
    begin
        bad_next = eq_multi_reg || encl_multi_reg;
        if (any_partial_reg)
        begin
            cls_next = CLS_PARTIAL;
            bad_next = bad_next || eq_seen_reg;
        end
        else if (eq_seen_reg)
        begin
            cls_next = CLS_EXACT;
            bad_next = bad_next || encl_seen_reg || any_contained_reg;
        end
        else if (encl_seen_reg)
        begin
            cls_next = CLS_CONTAINED;
            bad_next = bad_next || any_contained_reg;
        end
        else if (any_contained_reg)
        begin
            cls_next = CLS_CONTAINS;
        end
        else
        begin
            cls_next = CLS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            slot_valid_reg    <= '0;
            done_reg          <= 1'b0;
            eq_seen_reg       <= 1'b0;
            eq_multi_reg      <= 1'b0;
            encl_seen_reg     <= 1'b0;
            encl_multi_reg    <= 1'b0;
            any_contained_reg <= 1'b0;
            any_partial_reg   <= 1'b0;
            ovl_mask_reg      <= '0;
            inval_reg         <= 1'b0;
            alloc_reg         <= 1'b0;
            placed_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg           <= '0;
                        eq_seen_reg       <= 1'b0;
                        eq_multi_reg      <= 1'b0;
                        encl_seen_reg     <= 1'b0;
                        encl_multi_reg    <= 1'b0;
                        any_contained_reg <= 1'b0;
                        any_partial_reg   <= 1'b0;
                        state_reg         <= S_CLASSIFY;
                    end
                end
                S_CLASSIFY:
                begin
                    ovl_mask_reg[idx_reg] <= hit;
                    if (hit)
                    begin
                        if (cmp.equal)
                        begin
                            eq_multi_reg <= eq_multi_reg || eq_seen_reg;
                            eq_seen_reg  <= 1'b1;
                        end
                        else if (cmp.slot_encloses)
                        begin
                            encl_multi_reg <= encl_multi_reg || encl_seen_reg;
                            encl_seen_reg  <= 1'b1;
                        end
                        else if (cmp.region_encloses)
                        begin
                            any_contained_reg <= 1'b1;
                        end
                        else
                        begin
                            any_partial_reg <= 1'b1;
                        end
                    end
                    if (last)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    if (!bad_next && kind_reg == KIND_UPDATE && size_nz
                        && cls_next != CLS_EXACT && cls_next != CLS_CONTAINED)
                    begin
                        inval_reg  <= (cls_next == CLS_PARTIAL) || (cls_next == CLS_CONTAINS);
                        alloc_reg  <= (cls_next == CLS_CONTAINS) || (cls_next == CLS_NONE);
                        placed_reg <= 1'b0;
                        idx_reg    <= '0;
                        state_reg  <= S_UPDATE;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_UPDATE:
                begin
                    if (inval_reg && ovl_mask_reg[idx_reg])
                    begin
                        slot_valid_reg[idx_reg] <= 1'b0;
                    end
                    if (do_alloc)
                    begin
                        slot_valid_reg[idx_reg] <= 1'b1;
                        placed_reg              <= 1'b1;
                    end
                    if (last)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: captured transaction, enclosing slot, table entries, result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg   <= cmd.kind;
            r_off_reg  <= cmd.region_offset;
            r_size_reg <= cmd.region_size;
            r_end_reg  <= {1'b0, cmd.region_offset} + {61'd0, cmd.region_size};
        end
        if (state_reg == S_CLASSIFY && hit && !cmp.equal && cmp.slot_encloses)
        begin
            encl_off_reg <= slot_start_reg[idx_reg];
            encl_len_reg <= slot_length_reg[idx_reg];
        end
        if (do_alloc)
        begin
            slot_start_reg[idx_reg]  <= r_off_reg;
            slot_length_reg[idx_reg] <= r_size_reg;
        end
        if (state_reg == S_DECIDE)
        begin
            result_reg.match_class      <= cls_next;
            result_reg.status           <= ST_OK;
            result_reg.found            <= 1'b0;
            result_reg.enclosing_offset <= 64'd0;
            result_reg.enclosing_size   <= 4'd0;
            if (bad_next)
            begin
                result_reg.status <= ST_INCONSISTENT;
            end
            else if (kind_reg == KIND_LOOKUP)
            begin
                if (cls_next == CLS_EXACT)
                begin
                    result_reg.found            <= 1'b1;
                    result_reg.enclosing_offset <= r_off_reg;
                    result_reg.enclosing_size   <= r_size_reg;
                end
                else if (cls_next == CLS_CONTAINED)
                begin
                    result_reg.found            <= 1'b1;
                    result_reg.enclosing_offset <= encl_off_reg;
                    result_reg.enclosing_size   <= encl_len_reg;
                end
                else if (cls_next == CLS_CONTAINS)
                begin
                    result_reg.status <= ST_LOOKUP_CONTS;
                end
            end
        end
        // no vacant slot by the end of the pass: table full
        if (state_reg == S_UPDATE && last && alloc_reg && !placed_reg && !vacant)
        begin
            result_reg.status <= ST_FULL;
        end
    end

    // a result only follows work in progress
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // table is only touched while busy
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> $stable(slot_valid_reg))
        else $error("slot table changed while idle");

    // full table is only reported for an allocating class
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_FULL) |->
        (result.match_class == CLS_NONE || result.match_class == CLS_CONTAINS))
        else $error("table full with a non-allocating class");

    // an enclosing region is only reported on success
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == ST_OK))
        else $error("found set with error status");

endmodule

>>> verif/tb_overlapping_region_slot_map_unit.sv
// Testbench for the overlapping region slot map unit: directed and random accesses, scoreboard.
`timescale 1ns / 1ps

module tb_overlapping_region_slot_map_unit;
    import orsm_pkg::*;

    localparam int SLOTS          = SLOT_COUNT_DEF;
    localparam int RANDOM_TARGET  = 750;
    localparam int QUIET_TAIL     = 150;   // last transactions run with no gaps
    localparam int SETTLE_CYCLES  = 40;    // covers the longest transaction
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no command or result taken
    localparam logic [63:0] TOP_BASE = 64'hFFFF_FFFF_FFFF_FFC0;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  cmd = '0;
    logic busy;
    logic done;
    out_t result;

    overlapping_region_slot_map_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the slot table; reset leaves it empty.
    logic        slot_live [SLOTS];
    logic [63:0] slot_base [SLOTS];
    logic [3:0]  slot_len  [SLOTS];

    in_t  pending_accesses[$];   // commands not yet taken by the block
    out_t predicted_replies[$];  // replies owed for commands already taken

    int taken_count = 0;
    int quiet_from  = 0;
    int gap_left    = 0;
    bit gaps_on     = 1'b1;
    int mismatches  = 0;
    int stall_count = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // End address as a 65-bit sum, so a region touching 2^64 does not wrap.
    function automatic logic [64:0] region_end(logic [63:0] o, logic [3:0] s);
        return {1'b0, o} + {61'd0, s};
    endfunction

    function automatic bit regions_overlap(logic [63:0] ao, logic [3:0] as_,
                                           logic [63:0] bo, logic [3:0] bs);
        return ({1'b0, ao} < region_end(bo, bs)) && ({1'b0, bo} < region_end(ao, as_));
    endfunction

    function automatic bit region_encloses(logic [63:0] oo, logic [3:0] os,
                                           logic [63:0] io, logic [3:0] is_);
        return (oo <= io) && (region_end(io, is_) <= region_end(oo, os));
    endfunction

    // Classify one access against the shadow table, apply it, and return the reply.
    function automatic out_t map_access(in_t acc);
        out_t        r;
        int          n_equal;
        int          n_encl;
        int          encl_idx;
        bit          any_contained;
        bit          any_partial;
        bit          bad;
        bit          placed;
        logic [2:0]  cls;
        r             = '0;
        n_equal       = 0;
        n_encl        = 0;
        encl_idx      = 0;
        any_contained = 1'b0;
        any_partial   = 1'b0;
        placed        = 1'b0;
        if (acc.region_size != 4'd0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_live[i] || !regions_overlap(acc.region_offset, acc.region_size,
                                                      slot_base[i], slot_len[i]))
                    continue;
                if (slot_base[i] == acc.region_offset && slot_len[i] == acc.region_size)
                    n_equal++;
                else if (region_encloses(slot_base[i], slot_len[i],
                                         acc.region_offset, acc.region_size))
                begin
                    n_encl++;
                    encl_idx = i;
                end
                else if (region_encloses(acc.region_offset, acc.region_size,
                                         slot_base[i], slot_len[i]))
                    any_contained = 1'b1;
                else
                    any_partial = 1'b1;
            end
        end

        // priority: partial, exact, contained, contains, none
        bad = (n_equal > 1) || (n_encl > 1);
        if (any_partial)
        begin
            cls = CLS_PARTIAL;
            bad = bad || (n_equal != 0);
        end
        else if (n_equal != 0)
        begin
            cls = CLS_EXACT;
            bad = bad || (n_encl != 0) || any_contained;
        end
        else if (n_encl != 0)
        begin
            cls = CLS_CONTAINED;
            bad = bad || any_contained;
        end
        else if (any_contained)
            cls = CLS_CONTAINS;
        else
            cls = CLS_NONE;
        r.match_class = cls;
        r.status      = ST_OK;

        if (bad)
            r.status = ST_INCONSISTENT;
        else if (acc.kind == KIND_UPDATE)
        begin
            if (acc.region_size != 4'd0 && (cls == CLS_PARTIAL || cls == CLS_CONTAINS))
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && regions_overlap(acc.region_offset, acc.region_size,
                                                        slot_base[i], slot_len[i]))
                        slot_live[i] = 1'b0;
            end
            if (acc.region_size != 4'd0 && (cls == CLS_CONTAINS || cls == CLS_NONE))
            begin
                for (int i = 0; i < SLOTS && !placed; i++)
                begin
                    if (!slot_live[i])
                    begin
                        slot_live[i] = 1'b1;
                        slot_base[i] = acc.region_offset;
                        slot_len[i]  = acc.region_size;
                        placed       = 1'b1;
                    end
                end
                if (!placed)
                    r.status = ST_FULL;
            end
        end
        else
        begin
            if (cls == CLS_EXACT)
            begin
                r.found            = 1'b1;
                r.enclosing_offset = acc.region_offset;
                r.enclosing_size   = acc.region_size;
            end
            else if (cls == CLS_CONTAINED)
            begin
                r.found            = 1'b1;
                r.enclosing_offset = slot_base[encl_idx];
                r.enclosing_size   = slot_len[encl_idx];
            end
            else if (cls == CLS_CONTAINS)
                r.status = ST_LOOKUP_CONTS;
        end
        return r;
    endfunction

    task automatic queue_access(logic kind, logic [63:0] off, logic [3:0] sz);
        in_t a;
        a.kind          = kind;
        a.region_offset = off;
        a.region_size   = sz;
        pending_accesses.push_back(a);
    endtask

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] base;
        int          span;
        int          group_len;
        int          roll;
        logic        kind;
        logic [3:0]  sz;

        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_base[i] = '0;
            slot_len[i]  = '0;
        end

        // Directed: zero sizes, each class, lookup status, top-of-space ends, sizes past 8.
        queue_access(KIND_UPDATE, 64'd0, 4'd0);
        queue_access(KIND_LOOKUP, '1, 4'd0);
        queue_access(KIND_UPDATE, 64'd0, 4'd8);
        queue_access(KIND_LOOKUP, 64'd0, 4'd8);
        queue_access(KIND_LOOKUP, 64'd2, 4'd3);
        queue_access(KIND_UPDATE, 64'd2, 4'd3);
        queue_access(KIND_UPDATE, 64'd6, 4'd4);       // partial: drops [0,8)
        queue_access(KIND_LOOKUP, 64'd0, 4'd8);
        queue_access(KIND_UPDATE, 64'd16, 4'd2);
        queue_access(KIND_UPDATE, 64'd20, 4'd2);
        queue_access(KIND_LOOKUP, 64'd15, 4'd8);      // lookup containing two slots
        queue_access(KIND_UPDATE, 64'd15, 4'd8);      // replaces both
        queue_access(KIND_LOOKUP, 64'd17, 4'd1);
        queue_access(KIND_UPDATE, '1, 4'd1);          // ends exactly at 2^64
        queue_access(KIND_LOOKUP, '1, 4'd1);
        queue_access(KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFF8, 4'd15);
        queue_access(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFA, 4'd2);
        queue_access(KIND_UPDATE, 64'hFFFF_FFFF_FFFF_FFF0, 4'd9);
        queue_access(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
        queue_access(KIND_UPDATE, 64'h8000_0000_0000_0000, 4'd15);
        queue_access(KIND_LOOKUP, 64'h8000_0000_0000_0007, 4'd1);
        queue_access(KIND_LOOKUP, 64'h5555_5555_5555_5555, 4'd4);
        queue_access(KIND_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd12);
        queue_access(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB, 4'd12);

        // Random: groups clustered around one base so regions keep colliding.
        while (pending_accesses.size() < RANDOM_TARGET + 24)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                base = 64'd0;
            else if (roll < 6)
                base = TOP_BASE;
            else
                base = {$urandom, $urandom};
            case ($urandom_range(0, 2))
                0:       span = 16;
                1:       span = 40;
                default: span = 63;
            endcase
            if ($urandom_range(0, 7) == 0)
            begin
                // disjoint run of updates that fills the table and overflows it
                for (int k = 0; k < SLOTS + 2; k++)
                    queue_access(KIND_UPDATE, base + 64'(8 * k), 4'($urandom_range(1, 8)));
                for (int k = 0; k < 4; k++)
                    queue_access(KIND_LOOKUP, base + 64'($urandom_range(0, 8 * SLOTS)),
                                 4'($urandom_range(1, 4)));
            end
            else
            begin
                group_len = $urandom_range(8, 40);
                for (int g = 0; g < group_len; g++)
                begin
                    roll = $urandom_range(0, 99);
                    kind = ($urandom_range(0, 99) < 35) ? KIND_LOOKUP : KIND_UPDATE;
                    if (roll < 5)
                        sz = 4'd0;
                    else if (roll < 12)
                        sz = 4'($urandom_range(9, 15));
                    else
                        sz = 4'($urandom_range(1, 8));
                    if ($urandom_range(0, 19) == 0)
                        queue_access(kind, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
                    else
                        queue_access(kind, base + 64'($urandom_range(0, span)), sz);
                end
            end
        end
        quiet_from = pending_accesses.size() - QUIET_TAIL;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (predicted_replies.size() != 0)
        begin
            mismatches++;
            $display("%0d replies never arrived", predicted_replies.size());
        end
        if (mismatches == 0)
            $display("overlapping_region_slot_map_unit: match");
        else
            $display("overlapping_region_slot_map_unit: mismatch");
        $finish;
    end

    // Command driver. A transaction is taken at an edge with start high and busy low.
    // Gaps are random bursts of low start, switched on and off in stretches, and may also
    // pull start down while the block is busy so gaps land on every phase of its work.
    always @(posedge clk or negedge rst_n)
    begin
        logic hold;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            hold = start;
            if (start && !busy)
            begin
                predicted_replies.push_back(map_access(pending_accesses.pop_front()));
                taken_count++;
                hold = 1'b0;
                if (taken_count % 40 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
            end
            if (taken_count >= quiet_from)
                gaps_on = 1'b0;

            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (hold)
            begin
                // same command still offered; maybe withdraw it for a while
                if (gaps_on && busy && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(0, 5);
                    start <= 1'b0;
                end
                else
                    start <= 1'b1;
            end
            else if (pending_accesses.size() != 0)
            begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                begin
                    gap_left = $urandom_range(0, 5);
                    start <= 1'b0;
                end
                else
                begin
                    start <= 1'b1;
                    cmd   <= pending_accesses[0];
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Reply monitor: done is a one-cycle strobe, sampled at the edge that ends it.
    always @(posedge clk)
    begin
        out_t want;
        bit   bad;
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] reply with none owed: ",
                              "status %0d class %0d found %0d off %h size %0d"},
                             $realtime, result.status, result.match_class, result.found,
                             result.enclosing_offset, result.enclosing_size);
            end
            else
            begin
                want = predicted_replies.pop_front();
                bad  = (result.status !== want.status)
                    || (result.match_class !== want.match_class)
                    || (result.found !== want.found)
                    || (result.enclosing_offset !== want.enclosing_offset)
                    || (result.enclosing_size !== want.enclosing_size);
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] expected status %0d class %0d found %0d off %h size %0d",
                                 $realtime, want.status, want.match_class, want.found,
                                 want.enclosing_offset, want.enclosing_size);
                        $display("[%0t] actual   status %0d class %0d found %0d off %h size %0d",
                                 $realtime, result.status, result.match_class, result.found,
                                 result.enclosing_offset, result.enclosing_size);
                    end
                end
            end
        end
    end

    // Watchdog: the run is hung if neither a command nor a reply moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count <= 0;
            else if (stall_count + 1 >= WATCHDOG_LIMIT)
            begin
                $display("overlapping_region_slot_map_unit: mismatch");
                $finish;
            end
            else
                stall_count <= stall_count + 1;
        end
    end

endmodule
